>>> rtl/twrtc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package twrtc_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned IdxW  = 4;
  localparam int unsigned WordW = 16;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_READ  = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  // Pin levels and status after one tick.
  typedef struct packed {
    logic [ByteW-1:0] rdata;
    logic             done_res;
    logic             busy_res;
    logic             io_drive;
    logic             io_out;
    logic             serial_clock;
    logic             chip_enable;
  } tick_res_t;

  // Binary to BCD with clamping at 99. The tens digit comes from a
  // multiplication by 205/2048, which is exact for every value up to 99.
  function automatic logic [ByteW-1:0] to_bcd(input logic [ByteW-1:0] v);
    logic [6:0]  c;
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  ones;
    begin
      c    = (v > ByteW'(99)) ? 7'd99 : v[6:0];
      prod = 15'(c) * 15'd205;
      tens = prod[14:11];
      ones = c - 7'((tens << 3) + (tens << 1));
      to_bcd = {tens, ones[3:0]};
    end
  endfunction

  // BCD to binary; nibbles above nine are still weighted by ten.
  function automatic logic [ByteW-1:0] from_bcd(input logic [ByteW-1:0] v);
    logic [ByteW-1:0] hi;
    begin
      hi = {4'd0, v[7:4]};
      from_bcd = (hi << 3) + (hi << 1) + {4'd0, v[3:0]};
    end
  endfunction

endpackage
`default_nettype wire

>>> rtl/twrtc_seq.sv
`timescale 1ns / 1ps
`default_nettype none
module twrtc_seq (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      step,
  input  wire logic [1:0]                req_type,
  input  wire logic [7:0]                command,
  input  wire logic [7:0]                wdata,
  input  wire logic                      use_bcd,
  input  wire logic                      io_in,
  input  wire logic [7:0]                half_period_ticks,
  output twrtc_pkg::tick_res_t           res
);
  import twrtc_pkg::*;

  logic             busy_flag, busy_flag_next;
  logic             is_read, is_read_next;
  logic             bcd_mode, bcd_mode_next;
  logic [IdxW-1:0]  bit_index, bit_index_next;
  logic             clock_phase, clock_phase_next;
  logic [ByteW-1:0] divider_count, divider_count_next;
  logic [WordW-1:0] shift_word, shift_word_next;
  logic [ByteW-1:0] capture_byte, capture_byte_next;

  logic [ByteW-1:0] limit;
  logic [ByteW:0]   div_inc;
  logic             finish;
  logic             drive;
  logic [ByteW-1:0] rd;
  logic [ByteW-1:0] cmd_eff;
  logic [ByteW-1:0] data_eff;
  req_t             req;

  always_comb begin
    req                = req_t'(req_type);
    busy_flag_next     = busy_flag;
    is_read_next       = is_read;
    bcd_mode_next      = bcd_mode;
    bit_index_next     = bit_index;
    clock_phase_next   = clock_phase;
    divider_count_next = divider_count;
    shift_word_next    = shift_word;
    capture_byte_next  = capture_byte;
    finish             = 1'b0;
    rd                 = '0;
    limit              = (half_period_ticks == '0) ? ByteW'(1) : half_period_ticks;
    div_inc            = {1'b0, divider_count} + (ByteW+1)'(1);
    cmd_eff            = command;
    data_eff           = '0;

    if (!busy_flag) begin
      if (req == REQ_WRITE || req == REQ_READ) begin
        if (req == REQ_READ) begin
          cmd_eff = command | ByteW'(1);
        end else begin
          data_eff = use_bcd ? to_bcd(wdata) : wdata;
        end
        is_read_next       = (req == REQ_READ);
        bcd_mode_next      = use_bcd;
        shift_word_next    = {data_eff, cmd_eff};
        busy_flag_next     = 1'b1;
        bit_index_next     = '0;
        clock_phase_next   = 1'b0;
        divider_count_next = '0;
        capture_byte_next  = '0;
      end
    end else if (div_inc >= {1'b0, limit}) begin
      divider_count_next = '0;
      if (!clock_phase) begin
        // Sample at the end of the low half after each falling edge.
        if (is_read && bit_index[3]) begin
          capture_byte_next[bit_index[2:0]] = capture_byte[bit_index[2:0]] | io_in;
        end
        if (is_read && bit_index == '1) begin
          finish = 1'b1;
        end else begin
          clock_phase_next = 1'b1;
        end
      end else begin
        clock_phase_next = 1'b0;
        if (bit_index == '1) begin
          finish = 1'b1;
        end else begin
          bit_index_next = bit_index + IdxW'(1);
        end
      end
      if (finish) begin
        busy_flag_next   = 1'b0;
        bit_index_next   = '0;
        clock_phase_next = 1'b0;
        if (is_read) begin
          rd = bcd_mode ? from_bcd(capture_byte_next) : capture_byte_next;
        end
      end
    end else begin
      divider_count_next = div_inc[ByteW-1:0];
    end

    drive = busy_flag_next && (!is_read_next || !bit_index_next[3]);
    res.chip_enable  = busy_flag_next;
    res.serial_clock = busy_flag_next && clock_phase_next;
    res.io_drive     = drive;
    res.io_out       = drive && shift_word_next[bit_index_next];
    res.busy_res     = busy_flag_next;
    res.done_res     = finish;
    res.rdata        = rd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy_flag     <= 1'b0;
      is_read       <= 1'b0;
      bcd_mode      <= 1'b0;
      bit_index     <= '0;
      clock_phase   <= 1'b0;
      divider_count <= '0;
      shift_word    <= '0;
      capture_byte  <= '0;
    end else if (step) begin
      busy_flag     <= busy_flag_next;
      is_read       <= is_read_next;
      bcd_mode      <= bcd_mode_next;
      bit_index     <= bit_index_next;
      clock_phase   <= clock_phase_next;
      divider_count <= divider_count_next;
      shift_word    <= shift_word_next;
      capture_byte  <= capture_byte_next;
    end
  end

endmodule
`default_nettype wire

>>> rtl/three_wire_rtc_serial_master.sv
`timescale 1ns / 1ps
`default_nettype none
// Three-wire serial master for a real-time-clock chip. Each input transaction
// is one tick of the pin sequencer and yields exactly one output transaction
// carrying the pin levels and status after that tick. One transaction is taken
// every cycle: the sequencer state advances on acceptance and the result goes
// to an output register, so input is stalled only while that register holds a
// result that has not been taken. cfg_we writes the number of ticks per serial
// clock half period (zero behaves as one); write it only while the sequencer is
// idle.
module three_wire_rtc_serial_master (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // command[7:0], wdata[15:8], use_bcd[16], io_in[17], zero pad[23:18]
  input  wire logic [23:0] s_axis_tdata,
  // req_type[1:0]
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // chip_enable[0], serial_clock[1], io_out[2], io_drive[3], busy_res[4],
  // done_res[5], rdata[13:6], zero pad[15:14]
  output logic [15:0]      m_axis_tdata,
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_wdata
);
  import twrtc_pkg::*;

  logic [ByteW-1:0] half_period_ticks;
  logic             step;
  tick_res_t        res;
  logic [13:0]      out_word;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign step          = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period_ticks <= ByteW'(1);
    end else if (cfg_we) begin
      half_period_ticks <= cfg_wdata;
    end
  end

  twrtc_seq u_seq (
    .clk               (clk),
    .rst               (rst),
    .step              (step),
    .req_type          (s_axis_tuser),
    .command           (s_axis_tdata[7:0]),
    .wdata             (s_axis_tdata[15:8]),
    .use_bcd           (s_axis_tdata[16]),
    .io_in             (s_axis_tdata[17]),
    .half_period_ticks (half_period_ticks),
    .res               (res)
  );

  assign out_word = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s_axis_tready) begin
      m_axis_tvalid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      m_axis_tdata <= {2'b00, out_word};
    end
  end

endmodule
`default_nettype wire

>>> rtl/twrtc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module twrtc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata
);

  // A stalled result keeps its contents.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed while stalled");

  // The serial clock only toggles inside a transfer.
  a_sclk_in_ce: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !m_axis_tdata[1] || m_axis_tdata[0])
    else $error("serial clock high with chip enable low");

  // A finishing tick has already dropped chip enable and busy.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[5] |-> !m_axis_tdata[4] && !m_axis_tdata[0])
    else $error("done while still busy");

  // The data pin reads low whenever it is released.
  a_io_drive: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !m_axis_tdata[2] || m_axis_tdata[3])
    else $error("io_out high while not driving");

  // Read data is only presented with done.
  a_rdata_done: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[5] |-> m_axis_tdata[13:6] == 8'd0)
    else $error("rdata non-zero without done");

endmodule

bind three_wire_rtc_serial_master twrtc_checker u_twrtc_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

>>> sim/tb_three_wire_rtc_serial_master.sv
`timescale 1ns / 1ps
module tb_three_wire_rtc_serial_master;
  import twrtc_pkg::*;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic        cfg_we;
  logic [7:0]  cfg_wdata;

  three_wire_rtc_serial_master DUT (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Shadow copy of the pin sequencer, advanced once per accepted tick.
  logic        sq_busy  = 1'b0;
  logic        sq_read  = 1'b0;
  logic        sq_bcd   = 1'b0;
  logic [4:0]  sq_bit   = '0;
  logic        sq_phase = 1'b0;
  logic [7:0]  sq_div   = '0;
  logic [15:0] sq_word  = '0;
  logic [7:0]  sq_cap   = '0;
  logic [7:0]  sq_half  = 8'd1;

  tick_res_t pin_levels_q[$];

  int  err_cnt      = 0;
  int  ticks_sent   = 0;
  int  results_seen = 0;
  int  writes_done  = 0;
  int  reads_done   = 0;
  int  settings_cnt = 0;
  bit  tx_idle      = 1'b1;
  bit  rx_idle      = 1'b1;
  bit  hold_req     = 1'b0;

  typedef struct {
    req_t       kind;
    logic [7:0] cmd;
    logic [7:0] wd;
    logic       bcd;
    logic [7:0] dev_byte;  // byte the device returns on a read
    bit         poke;      // issue ignored requests during the transfer
    logic [7:0] half;
    bit         typed;
    tick_res_t  want;      // pins on the first tick, when typed
  } xfer_row_t;

  xfer_row_t xfer_table [19];

  function automatic logic [7:0] bin_to_bcd(input logic [7:0] v);
    logic [7:0] c;
    c = (v > 8'd99) ? 8'd99 : v;
    return ((c / 8'd10) << 4) | (c % 8'd10);
  endfunction

  function automatic logic [7:0] bcd_to_bin(input logic [7:0] v);
    return v[7:4] * 8'd10 + {4'd0, v[3:0]};
  endfunction

  function automatic tick_res_t start_pins(input logic first_bit);
    tick_res_t r;
    r              = '0;
    r.chip_enable  = 1'b1;
    r.io_out       = first_bit;
    r.io_drive     = 1'b1;
    r.busy_res     = 1'b1;
    return r;
  endfunction

  function automatic tick_res_t sequencer_tick(input logic [1:0] rq, input logic [7:0] cmd,
                                               input logic [7:0] wd, input logic bcd,
                                               input logic io);
    tick_res_t  r;
    logic [7:0] data;
    logic [7:0] lim;
    logic [8:0] nxt;
    logic       fin;
    logic       drv;
    r   = '0;
    fin = 1'b0;
    if (!sq_busy) begin
      if (rq == REQ_WRITE || rq == REQ_READ) begin
        sq_read = (rq == REQ_READ);
        sq_bcd  = bcd;
        data    = 8'd0;
        if (sq_read) begin
          sq_word = {data, cmd | 8'h01};
        end else begin
          data    = bcd ? bin_to_bcd(wd) : wd;
          sq_word = {data, cmd};
        end
        sq_busy  = 1'b1;
        sq_bit   = '0;
        sq_phase = 1'b0;
        sq_div   = '0;
        sq_cap   = '0;
      end
    end else begin
      lim = (sq_half == 8'd0) ? 8'd1 : sq_half;
      nxt = {1'b0, sq_div} + 9'd1;
      if (nxt >= {1'b0, lim}) begin
        sq_div = '0;
        if (!sq_phase) begin
          // Data bits are sampled at the end of each low half period.
          if (sq_read && sq_bit >= 5'd8) sq_cap = sq_cap | (8'(io) << sq_bit[2:0]);
          if (sq_read && sq_bit >= 5'd15) fin = 1'b1;
          else sq_phase = 1'b1;
        end else begin
          sq_phase = 1'b0;
          if (sq_bit >= 5'd15) fin = 1'b1;
          else sq_bit = sq_bit + 5'd1;
        end
        if (fin) begin
          sq_busy    = 1'b0;
          r.done_res = 1'b1;
          if (sq_read) begin
            r.rdata = sq_bcd ? bcd_to_bin(sq_cap) : sq_cap;
            reads_done++;
          end else begin
            writes_done++;
          end
          sq_bit   = '0;
          sq_phase = 1'b0;
        end
      end else begin
        sq_div = nxt[7:0];
      end
    end
    drv            = sq_busy && (!sq_read || sq_bit < 5'd8);
    r.chip_enable  = sq_busy;
    r.serial_clock = sq_busy & sq_phase;
    r.io_drive     = drv;
    r.io_out       = drv ? sq_word[sq_bit[3:0]] : 1'b0;
    r.busy_res     = sq_busy;
    return r;
  endfunction

  // Offers one tick and waits until it is accepted; typed rows override the prediction.
  task automatic put_tick(input req_t rq, input logic [7:0] cmd, input logic [7:0] wd,
                          input logic bcd, input logic io, input bit typed,
                          input tick_res_t want);
    int        gap;
    tick_res_t pv;
    gap = tx_idle ? $urandom_range(0, 7) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= rq;
    s_axis_tdata  <= {6'd0, io, bcd, wd, cmd};
    do @(posedge clk); while (!s_axis_tready);
    pv = sequencer_tick(rq, cmd, wd, bcd, io);
    pin_levels_q.push_back(typed ? want : pv);
    ticks_sent++;
  endtask

  // Runs any transfer to its end and waits until every result has been taken.
  task automatic settle();
    int waited;
    while (sq_busy)
      put_tick(REQ_TICK, 8'($urandom), 8'($urandom), 1'($urandom), 1'($urandom), 1'b0, '0);
    s_axis_tvalid <= 1'b0;
    waited = 0;
    while (pin_levels_q.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    if (pin_levels_q.size() != 0) begin
      err_cnt += pin_levels_q.size();
      $display("%0t: %0d expected results never arrived", $time, pin_levels_q.size());
      pin_levels_q.delete();
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_half(input logic [7:0] v);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sq_half = v;
    settings_cnt++;
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      err_cnt++;
      if (err_cnt <= 40)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Receiving side: random back-pressure, one long hold when asked for.
  initial begin : rx_side
    int        gap;
    tick_res_t want;
    tick_res_t got;
    m_axis_tready = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk);
      end else begin
        gap = rx_idle ? $urandom_range(0, 7) : 0;
        if (gap != 0) begin
          m_axis_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      results_seen++;
      got = tick_res_t'(m_axis_tdata[13:0]);
      if (pin_levels_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 40)
          $display("%0t: result with no expectation, expected none, actual %h", $time,
                   m_axis_tdata);
      end else begin
        want = pin_levels_q.pop_front();
        check_field("chip_enable", want.chip_enable, got.chip_enable);
        check_field("serial_clock", want.serial_clock, got.serial_clock);
        check_field("io_out", want.io_out, got.io_out);
        check_field("io_drive", want.io_drive, got.io_drive);
        check_field("busy_res", want.busy_res, got.busy_res);
        check_field("done_res", want.done_res, got.done_res);
        check_field("rdata", want.rdata, got.rdata);
        check_field("pad bits", 0, m_axis_tdata[15:14]);
      end
    end
  end

  initial begin : tx_side
    logic [7:0] halves [7];
    req_t       rq;
    logic [7:0] wd;
    int         i;
    int         ph;
    int         pick;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = REQ_TICK;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;

    xfer_table = '{
      '{REQ_TICK,  8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 8'd1,   1'b1, '0},
      '{REQ_NONE,  8'hFF, 8'hFF, 1'b1, 8'hFF, 1'b0, 8'd1,   1'b1, '0},
      '{REQ_WRITE, 8'h80, 8'h00, 1'b0, 8'h00, 1'b0, 8'd1,   1'b1, start_pins(1'b0)},
      '{REQ_WRITE, 8'hFF, 8'hFF, 1'b0, 8'h00, 1'b0, 8'd1,   1'b1, start_pins(1'b1)},
      '{REQ_WRITE, 8'h8E, 8'h00, 1'b0, 8'h00, 1'b1, 8'd1,   1'b0, '0},
      '{REQ_WRITE, 8'h81, 8'd99, 1'b1, 8'h00, 1'b0, 8'd1,   1'b0, '0},
      '{REQ_WRITE, 8'h82, 8'd100, 1'b1, 8'h00, 1'b0, 8'd1,  1'b0, '0},
      '{REQ_WRITE, 8'h83, 8'hFF, 1'b1, 8'h00, 1'b0, 8'd1,   1'b0, '0},
      '{REQ_READ,  8'h80, 8'h00, 1'b0, 8'h00, 1'b0, 8'd1,   1'b1, start_pins(1'b1)},
      '{REQ_READ,  8'hFE, 8'hFF, 1'b0, 8'hFF, 1'b0, 8'd1,   1'b1, start_pins(1'b1)},
      '{REQ_READ,  8'h81, 8'h00, 1'b1, 8'h59, 1'b0, 8'd1,   1'b0, '0},
      '{REQ_READ,  8'h85, 8'h00, 1'b1, 8'hFF, 1'b0, 8'd1,   1'b0, '0},
      '{REQ_READ,  8'h87, 8'h00, 1'b1, 8'hA5, 1'b1, 8'd1,   1'b0, '0},
      '{REQ_WRITE, 8'h01, 8'hAA, 1'b0, 8'h00, 1'b0, 8'd0,   1'b1, start_pins(1'b1)},
      '{REQ_READ,  8'h00, 8'h00, 1'b1, 8'h99, 1'b1, 8'd0,   1'b0, '0},
      '{REQ_WRITE, 8'h55, 8'h5A, 1'b1, 8'h00, 1'b0, 8'd2,   1'b0, '0},
      '{REQ_READ,  8'hAA, 8'h00, 1'b0, 8'hC3, 1'b1, 8'd3,   1'b0, '0},
      '{REQ_WRITE, 8'h7F, 8'h80, 1'b0, 8'h00, 1'b0, 8'd5,   1'b0, '0},
      '{REQ_READ,  8'h8F, 8'h00, 1'b1, 8'h37, 1'b0, 8'd5,   1'b0, '0}
    };

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed transfers: the first tick of each is the table row, the rest
    // feed the device byte back on the data pin bit by bit.
    for (i = 0; i < 19; i++) begin
      if (xfer_table[i].half != sq_half) write_half(xfer_table[i].half);
      put_tick(xfer_table[i].kind, xfer_table[i].cmd, xfer_table[i].wd, xfer_table[i].bcd,
               1'b0, xfer_table[i].typed, xfer_table[i].want);
      while (sq_busy) begin
        if (xfer_table[i].poke) rq = $urandom_range(0, 1) ? REQ_READ : REQ_WRITE;
        else rq = REQ_TICK;
        put_tick(rq, 8'($urandom), 8'($urandom), 1'($urandom),
                 xfer_table[i].dev_byte[sq_bit[2:0]], 1'b0, '0);
      end
    end

    halves = '{8'd1, 8'd0, 8'd2, 8'd1, 8'd3, 8'($urandom_range(1, 6)), 8'd1};
    for (ph = 0; ph < 7; ph++) begin
      write_half(halves[ph]);
      tx_idle = (ph == 3) ? 1'b0 : 1'($urandom_range(0, 3) != 0);
      rx_idle = (ph == 3) ? 1'b0 : 1'($urandom_range(0, 3) != 0);
      if (ph == 1) begin
        tx_idle  = 1'b0;
        hold_req = 1'b1;
      end
      for (i = 0; i < 120; i++) begin
        if (!sq_busy) begin
          pick = $urandom_range(0, 9);
          if (pick <= 6) rq = $urandom_range(0, 1) ? REQ_READ : REQ_WRITE;
          else if (pick == 8) rq = REQ_NONE;
          else rq = REQ_TICK;
        end else begin
          rq = ($urandom_range(0, 4) != 0) ? REQ_TICK : req_t'($urandom_range(0, 3));
        end
        // Keep many BCD writes in the unclamped range.
        wd = $urandom_range(0, 1) ? 8'($urandom_range(0, 110)) : 8'($urandom);
        put_tick(rq, 8'($urandom), wd, 1'($urandom), 1'($urandom), 1'b0, '0);
      end
    end

    settle();
    repeat (10) @(posedge clk);
    $display("Run covered %0d ticks and %0d results over %0d serial clock settings.",
             ticks_sent, results_seen, settings_cnt);
    $display("Completed %0d writes and %0d reads, with BCD conversion and ignored requests.",
             writes_done, reads_done);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

>>> files.f
rtl/twrtc_pkg.sv
rtl/twrtc_seq.sv
rtl/three_wire_rtc_serial_master.sv
rtl/twrtc_checker.sv
sim/tb_three_wire_rtc_serial_master.sv
